// File: rtl/core/v3alu_pkg.sv
// shared types and constants of the three-component vector alu
package v3alu_pkg;

	// default number of fraction bits of the fixed-point format
	localparam int unsigned FRAC_BITS_DEF = 16;

	// one fixed-point component
	typedef logic signed [31:0] fix_t;

	// operation codes
	typedef enum logic [2:0] {
		ACT_ADD   = 3'd0,
		ACT_SUB   = 3'd1,
		ACT_CROSS = 3'd2,
		ACT_DOT   = 3'd3,
		ACT_SCALE = 3'd4,
		ACT_DIV   = 3'd5,
		ACT_NORM  = 3'd6,
		ACT_EQ    = 3'd7
	} action_t;

endpackage

// File: rtl/core/v3alu_req_if.sv
// request channel of the vector alu: operation, two vectors and a scalar
interface v3alu_req_if;
	import v3alu_pkg::*;

	logic    valid;
	logic    ready;
	action_t action;
	fix_t    a_x;
	fix_t    a_y;
	fix_t    a_z;
	fix_t    b_x;
	fix_t    b_y;
	fix_t    b_z;
	fix_t    scalar_in;

	modport source (
		output valid, action, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
		input  ready
	);
	modport sink (
		input  valid, action, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
		output ready
	);
endinterface

// File: rtl/core/v3alu_rsp_if.sv
// response channel of the vector alu: result vector, scalar and flags
interface v3alu_rsp_if;
	import v3alu_pkg::*;

	logic valid;
	logic ready;
	fix_t r_x;
	fix_t r_y;
	fix_t r_z;
	fix_t scalar_out;
	logic overflow;
	logic div_zero;

	modport source (
		output valid, r_x, r_y, r_z, scalar_out, overflow, div_zero,
		input  ready
	);
	modport sink (
		input  valid, r_x, r_y, r_z, scalar_out, overflow, div_zero,
		output ready
	);
endinterface

// File: rtl/core/vec3_arithmetic_unit.sv
// Three-component vector alu in signed fixed point (add, sub, cross, dot, scale,
// divide, normalize, equal) with rounding and saturation. The unit is a fixed
// pipeline of 72 register stages: a beat accepted on req passes through all of
// them to rsp, and a new beat can enter every cycle when nothing stalls. The
// depth is set by the 32-step square-root chain that yields the vector length
// and the 32-step restoring divider lanes that serve divide and normalize;
// every operation goes through them so results leave in order. Each stage only
// holds when it is full and the stage after it holds, so bubbles close up and
// beats are still taken while a finished result waits on rsp.
module vec3_arithmetic_unit #(
	parameter int unsigned FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	v3alu_req_if.sink    req,
	v3alu_rsp_if.source  rsp
);
	import v3alu_pkg::*;

	localparam int unsigned NR   = 32;              // square-root steps
	localparam int unsigned ND   = 32;              // quotient bits
	localparam int unsigned NW   = 33 + FRAC_BITS;  // rounded dividend width

	typedef struct packed {
		logic [2:0][31:0] r;
		logic [31:0]      sc;
		logic             ov;
		logic             dz;
	} res_t;

	typedef struct packed {
		action_t          op;
		logic [2:0][31:0] a;
		logic [31:0]      s;
		res_t             res;
		logic             nz;
	} car_t;

	typedef struct packed {
		logic [63:0] v;
		logic [63:0] rt;
	} rt_t;

	typedef struct packed {
		logic [31:0]      d;
		logic [2:0][31:0] lo;
		logic [2:0][31:0] rem;
		logic [2:0][31:0] q;
		logic [2:0]       sat;
		logic [2:0]       neg;
	} dv_t;

	// saturate a wide signed value to 32 bits, overflow flag on top
	function automatic logic [32:0] sat_wide(input logic signed [66:0] v);
		if (v > 67'sd2147483647) begin
			return {1'b1, 32'h7fff_ffff};
		end
		if (v < -67'sd2147483648) begin
			return {1'b1, 32'h8000_0000};
		end
		return {1'b0, v[31:0]};
	endfunction

	// drop the fraction bits of a product, rounding half up
	function automatic logic signed [66:0] rnd(input logic signed [66:0] v);
		return (v + (67'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	// stage enables: a stage moves when empty or when the next one moves
	logic en_s1, en_s2, en_s3, en_s4, en_s6, en_s8;
	logic en_rt [0:NR+1];
	logic en_dv [0:ND+1];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s6, vld_s8;
	logic vld_rt [0:NR];
	logic vld_dv [0:ND];

	assign en_s8 = !vld_s8 || rsp.ready;
	assign en_dv[ND+1] = en_s8;
	assign en_s6 = !vld_s6 || en_dv[0];
	assign en_rt[NR+1] = en_s6;
	assign en_s4 = !vld_s4 || en_rt[0];
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign req.ready = en_s1;

	// valid bits of the fixed stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= req.valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s6) vld_s6 <= vld_rt[NR];
			if (en_s8) vld_s8 <= vld_dv[ND];
		end
	end

	// stage 1: input register
	action_t            op_s1;
	logic signed [31:0] a_s1 [3];
	logic signed [31:0] b_s1 [3];
	logic signed [31:0] sc_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			op_s1   <= req.action;
			a_s1[0] <= req.a_x;
			a_s1[1] <= req.a_y;
			a_s1[2] <= req.a_z;
			b_s1[0] <= req.b_x;
			b_s1[1] <= req.b_y;
			b_s1[2] <= req.b_z;
			sc_s1   <= req.scalar_in;
		end
	end

	// stage 2: two products per lane, operands chosen by the operation
	action_t            op_s2;
	logic signed [31:0] a_s2 [3];
	logic signed [31:0] b_s2 [3];
	logic signed [31:0] sc_s2;
	logic signed [63:0] p0_s2 [3];
	logic signed [63:0] p1_s2 [3];

	for (genvar i = 0; i < 3; i++) begin : g_mul
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;
		logic signed [31:0] ma0, mb0, ma1, mb1;
		logic signed [63:0] pr0, pr1;

		always_comb begin
			ma0 = '0;
			mb0 = '0;
			ma1 = '0;
			mb1 = '0;
			case (op_s1)
				ACT_CROSS: begin
					ma0 = a_s1[J];
					mb0 = b_s1[K];
					ma1 = a_s1[K];
					mb1 = b_s1[J];
				end
				ACT_DOT: begin
					ma0 = a_s1[i];
					mb0 = b_s1[i];
				end
				ACT_SCALE: begin
					ma0 = a_s1[i];
					mb0 = sc_s1;
				end
				ACT_NORM: begin
					ma0 = a_s1[i];
					mb0 = a_s1[i];
				end
				default: ;
			endcase
		end

		assign pr0 = ma0 * mb0;
		assign pr1 = ma1 * mb1;

		always_ff @(posedge clk) begin
			if (en_s2) begin
				p0_s2[i] <= pr0;
				p1_s2[i] <= pr1;
				a_s2[i]  <= a_s1[i];
				b_s2[i]  <= b_s1[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			op_s2 <= op_s1;
			sc_s2 <= sc_s1;
		end
	end

	// stage 3: lane difference, add and sub, equality
	action_t            op_s3;
	logic signed [31:0] a_s3 [3];
	logic signed [31:0] sc_s3;
	logic signed [64:0] d_s3 [3];
	logic [31:0]        ar_s3 [3];
	logic               arov_s3 [3];
	logic               eq_s3;

	for (genvar i = 0; i < 3; i++) begin : g_lane3
		logic signed [32:0] as_sum;
		logic [32:0]        as_sat;

		always_comb begin
			if (op_s2 == ACT_SUB) begin
				as_sum = 33'(a_s2[i]) - 33'(b_s2[i]);
			end else begin
				as_sum = 33'(a_s2[i]) + 33'(b_s2[i]);
			end
			as_sat = sat_wide(67'(as_sum));
		end

		always_ff @(posedge clk) begin
			if (en_s3) begin
				d_s3[i]    <= 65'(p0_s2[i]) - 65'(p1_s2[i]);
				ar_s3[i]   <= as_sat[31:0];
				arov_s3[i] <= as_sat[32];
				a_s3[i]    <= a_s2[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			op_s3 <= op_s2;
			sc_s3 <= sc_s2;
			eq_s3 <= (a_s2[0] == b_s2[0]) && (a_s2[1] == b_s2[1]) && (a_s2[2] == b_s2[2]);
		end
	end

	// stage 4: round and saturate each lane, sum the lanes
	action_t            op_s4;
	logic signed [31:0] a_s4 [3];
	logic signed [31:0] sc_s4;
	logic signed [66:0] tot_s4;
	logic [31:0]        lr_s4 [3];
	logic               lov_s4 [3];
	logic [31:0]        ar_s4 [3];
	logic               arov_s4 [3];
	logic               eq_s4;

	for (genvar i = 0; i < 3; i++) begin : g_lane4
		logic [32:0] ls;

		assign ls = sat_wide(rnd(67'(d_s3[i])));

		always_ff @(posedge clk) begin
			if (en_s4) begin
				lr_s4[i]   <= ls[31:0];
				lov_s4[i]  <= ls[32];
				ar_s4[i]   <= ar_s3[i];
				arov_s4[i] <= arov_s3[i];
				a_s4[i]    <= a_s3[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			op_s4  <= op_s3;
			sc_s4  <= sc_s3;
			eq_s4  <= eq_s3;
			tot_s4 <= 67'(d_s3[0]) + 67'(d_s3[1]) + 67'(d_s3[2]);
		end
	end

	// stage 5: pick the early result, start the root with the sum of squares
	car_t car_rt [0:NR];
	rt_t  rt_s [0:NR];
	car_t car_n;
	logic [32:0] dot_sat;

	assign dot_sat = sat_wide(rnd(tot_s4));

	always_comb begin
		car_n.op  = op_s4;
		car_n.s   = sc_s4;
		car_n.res = '0;
		car_n.nz  = (op_s4 == ACT_NORM) && (tot_s4[63:0] != 64'd0);
		for (int i = 0; i < 3; i++) begin
			car_n.a[i] = a_s4[i];
		end
		case (op_s4)
			ACT_ADD, ACT_SUB: begin
				for (int i = 0; i < 3; i++) begin
					car_n.res.r[i] = ar_s4[i];
				end
				car_n.res.ov = arov_s4[0] | arov_s4[1] | arov_s4[2];
			end
			ACT_CROSS, ACT_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					car_n.res.r[i] = lr_s4[i];
				end
				car_n.res.ov = lov_s4[0] | lov_s4[1] | lov_s4[2];
			end
			ACT_DOT: begin
				car_n.res.sc = dot_sat[31:0];
				car_n.res.ov = dot_sat[32];
			end
			ACT_DIV: begin
				// zero divisor: each component goes to the limit of its sign
				if (sc_s4 == 32'sd0) begin
					car_n.res.dz = 1'b1;
					for (int i = 0; i < 3; i++) begin
						if (a_s4[i] > 32'sd0) begin
							car_n.res.r[i] = 32'h7fff_ffff;
							car_n.res.ov   = 1'b1;
						end else if (a_s4[i] < 32'sd0) begin
							car_n.res.r[i] = 32'h8000_0000;
							car_n.res.ov   = 1'b1;
						end
					end
				end
			end
			ACT_NORM: begin
				for (int i = 0; i < 3; i++) begin
					car_n.res.r[i] = a_s4[i];
				end
			end
			ACT_EQ: begin
				car_n.res.sc = {31'd0, eq_s4};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_rt[0] <= 1'b0;
		end else if (en_rt[0]) begin
			vld_rt[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_rt[0]) begin
			car_rt[0] <= car_n;
			rt_s[0]   <= '{v: tot_s4[63:0], rt: 64'd0};
		end
	end

	// integer square root, one result bit per stage
	for (genvar k = 0; k <= NR; k++) begin : g_rt_en
		assign en_rt[k] = !vld_rt[k] || en_rt[k+1];
	end

	for (genvar k = 1; k <= NR; k++) begin : g_rt
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * (k - 1));
		logic [63:0] t;
		logic        ge;
		rt_t         nxt;

		always_comb begin
			t  = rt_s[k-1].rt + BIT;
			ge = rt_s[k-1].v >= t;
			if (ge) begin
				nxt.v  = rt_s[k-1].v - t;
				nxt.rt = (rt_s[k-1].rt >> 1) + BIT;
			end else begin
				nxt.v  = rt_s[k-1].v;
				nxt.rt = rt_s[k-1].rt >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_rt[k] <= 1'b0;
			end else if (en_rt[k]) begin
				vld_rt[k] <= vld_rt[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en_rt[k]) begin
				rt_s[k]   <= nxt;
				car_rt[k] <= car_rt[k-1];
			end
		end
	end

	// stage 6: divisor and rounded dividend per lane
	car_t        car_s6;
	logic [31:0] d_s6;
	logic [NW-1:0] n_s6 [3];
	logic [2:0]  neg_s6;
	logic [31:0] abs_s, dsel;

	always_comb begin
		abs_s = car_rt[NR].s[31] ? 32'(-car_rt[NR].s) : car_rt[NR].s;
		dsel  = (car_rt[NR].op == ACT_NORM) ? rt_s[NR].rt[31:0] : abs_s;
		if (dsel == 32'd0) begin
			dsel = 32'd1;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_dprep
		logic [31:0] abs_a;

		assign abs_a = car_rt[NR].a[i][31] ? 32'(-car_rt[NR].a[i]) : car_rt[NR].a[i];

		always_ff @(posedge clk) begin
			if (en_s6) begin
				n_s6[i]   <= (NW'(abs_a) << FRAC_BITS) + NW'(dsel >> 1);
				neg_s6[i] <= car_rt[NR].a[i][31]
					^ ((car_rt[NR].op != ACT_NORM) && car_rt[NR].s[31]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			car_s6 <= car_rt[NR];
			d_s6   <= dsel;
		end
	end

	// stage 7: range check and initial remainder
	car_t car_dv [0:ND];
	dv_t  dv_s [0:ND];
	dv_t  dv_n;

	always_comb begin
		dv_n.d   = d_s6;
		dv_n.neg = neg_s6;
		dv_n.q   = '0;
		for (int i = 0; i < 3; i++) begin
			dv_n.lo[i]  = n_s6[i][31:0];
			dv_n.rem[i] = 32'(n_s6[i][NW-1:32]);
			dv_n.sat[i] = 32'(n_s6[i][NW-1:32]) >= d_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_dv[0] <= 1'b0;
		end else if (en_dv[0]) begin
			vld_dv[0] <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en_dv[0]) begin
			car_dv[0] <= car_s6;
			dv_s[0]   <= dv_n;
		end
	end

	// restoring division, one quotient bit per stage in each lane
	for (genvar k = 0; k <= ND; k++) begin : g_dv_en
		assign en_dv[k] = !vld_dv[k] || en_dv[k+1];
	end

	for (genvar k = 1; k <= ND; k++) begin : g_dv
		dv_t nxt;

		always_comb begin
			logic [32:0] sh;
			logic        ge;
			nxt = dv_s[k-1];
			for (int i = 0; i < 3; i++) begin
				sh = {dv_s[k-1].rem[i], dv_s[k-1].lo[i][31]};
				ge = sh >= {1'b0, dv_s[k-1].d};
				nxt.rem[i] = ge ? 32'(sh - {1'b0, dv_s[k-1].d}) : sh[31:0];
				nxt.q[i]   = {dv_s[k-1].q[i][30:0], ge};
				nxt.lo[i]  = dv_s[k-1].lo[i] << 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_dv[k] <= 1'b0;
			end else if (en_dv[k]) begin
				vld_dv[k] <= vld_dv[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en_dv[k]) begin
				dv_s[k]   <= nxt;
				car_dv[k] <= car_dv[k-1];
			end
		end
	end

	// stage 8: sign and saturation of the quotients, output register
	action_t     op_s8;
	logic [31:0] r_s8 [3];
	logic [31:0] sc_s8;
	logic        ov_s8;
	logic        dz_s8;
	logic [31:0] fr [3];
	logic        fov [3];
	logic        use_div;

	assign use_div = ((car_dv[ND].op == ACT_DIV) && !car_dv[ND].res.dz)
		|| ((car_dv[ND].op == ACT_NORM) && car_dv[ND].nz);

	for (genvar i = 0; i < 3; i++) begin : g_fin
		always_comb begin
			fov[i] = 1'b0;
			fr[i]  = dv_s[ND].q[i];
			if (dv_s[ND].sat[i]) begin
				fov[i] = 1'b1;
				fr[i]  = dv_s[ND].neg[i] ? 32'h8000_0000 : 32'h7fff_ffff;
			end else if (dv_s[ND].neg[i]) begin
				if (dv_s[ND].q[i] > 32'h8000_0000) begin
					fov[i] = 1'b1;
					fr[i]  = 32'h8000_0000;
				end else begin
					fr[i] = 32'(-dv_s[ND].q[i]);
				end
			end else if (dv_s[ND].q[i] > 32'h7fff_ffff) begin
				fov[i] = 1'b1;
				fr[i]  = 32'h7fff_ffff;
			end
		end

		always_ff @(posedge clk) begin
			if (en_s8) begin
				r_s8[i] <= use_div ? fr[i] : car_dv[ND].res.r[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s8) begin
			op_s8 <= car_dv[ND].op;
			sc_s8 <= car_dv[ND].res.sc;
			dz_s8 <= car_dv[ND].res.dz;
			ov_s8 <= use_div ? (fov[0] | fov[1] | fov[2]) : car_dv[ND].res.ov;
		end
	end

	assign rsp.valid      = vld_s8;
	assign rsp.r_x        = r_s8[0];
	assign rsp.r_y        = r_s8[1];
	assign rsp.r_z        = r_s8[2];
	assign rsp.scalar_out = sc_s8;
	assign rsp.overflow   = ov_s8;
	assign rsp.div_zero   = dz_s8;

`ifndef SYNTHESIS
	// divide-by-zero flag only comes from a divide
	a_dz_op: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 && dz_s8 |-> op_s8 == ACT_DIV)
		else $error("div_zero on a non-divide beat");

	// divide by zero without overflow means an all-zero vector
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 && dz_s8 && !ov_s8 |-> r_s8[0] == 32'd0 && r_s8[1] == 32'd0
			&& r_s8[2] == 32'd0)
		else $error("zero divisor without overflow gave a nonzero vector");

	// normalize stays in range
	a_norm_ov: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 && op_s8 == ACT_NORM |-> !ov_s8)
		else $error("normalize reported overflow");

	// equal gives a plain 0 or 1 and a zero vector
	a_eq_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 && op_s8 == ACT_EQ |-> sc_s8[31:1] == 31'd0 && r_s8[0] == 32'd0
			&& r_s8[1] == 32'd0 && r_s8[2] == 32'd0 && !ov_s8)
		else $error("malformed equal result");
`endif

endmodule

// File: tb/vec3_arithmetic_unit_tb.sv
// self-checking testbench of the vector alu: queued stimulus, bursty sender, stalling receiver
module vec3_arithmetic_unit_tb;
	import v3alu_pkg::*;

	localparam int unsigned FB = 16;
	localparam int IDLE_LIMIT = 20000;
	localparam int N_RANDOM = 1250;

	typedef struct {
		action_t action;
		fix_t    a[3];
		fix_t    b[3];
		fix_t    s;
	} op_beat_t;

	typedef struct {
		fix_t r[3];
		fix_t sc;
		bit   ov;
		bit   dz;
	} alu_result_t;

	logic clk;
	logic arst_n;

	v3alu_req_if req ();
	v3alu_rsp_if rsp ();

	vec3_arithmetic_unit #(.FRAC_BITS(FB)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	op_beat_t    pending_ops[$];
	alu_result_t awaited_results[$];
	int          mismatches = 0;
	int          checked = 0;
	int          ov_seen = 0;
	int          dz_seen = 0;
	int          idle_cycles = 0;
	int          op_count[8];

	// clamp a wide value to 32 bits
	function automatic fix_t clamp32(logic signed [71:0] v, inout bit ov);
		if (v > 72'sh7fffffff) begin
			ov = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -72'sh80000000) begin
			ov = 1'b1;
			return 32'sh80000000;
		end
		return fix_t'(v[31:0]);
	endfunction

	// drop fraction bits, rounding half up
	function automatic logic signed [71:0] round_shift(logic signed [71:0] v);
		return (v + (72'sd1 <<< (FB - 1))) >>> FB;
	endfunction

	// fixed-point quotient, rounding half away from zero, saturated
	function automatic fix_t fix_quotient(longint n, longint d, inout bit ov);
		bit neg;
		longint unsigned un, ud, q;
		neg = (n < 0) != (d < 0);
		un = longint'(n < 0 ? -n : n) << FB;
		ud = (d < 0) ? -d : d;
		q = (un + ud / 2) / ud;
		if (neg) begin
			if (q > 64'h80000000) begin
				ov = 1'b1;
				return 32'sh80000000;
			end
			return fix_t'(-longint'(q));
		end
		if (q > 64'h7fffffff) begin
			ov = 1'b1;
			return 32'sh7fffffff;
		end
		return fix_t'(q);
	endfunction

	// floor square root of a 64-bit value
	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// expected response for one operation
	function automatic alu_result_t vector_alu_result(op_beat_t op);
		alu_result_t res;
		longint a[3], b[3], s;
		logic signed [71:0] p0, p1, p2;
		longint unsigned sq, mag;
		bit ov;
		ov = 1'b0;
		s = op.s;
		for (int i = 0; i < 3; i++) begin
			a[i] = op.a[i];
			b[i] = op.b[i];
			res.r[i] = '0;
		end
		res.sc = '0;
		res.dz = 1'b0;
		case (op.action)
			ACT_ADD: begin
				for (int i = 0; i < 3; i++) res.r[i] = clamp32(a[i] + b[i], ov);
			end
			ACT_SUB: begin
				for (int i = 0; i < 3; i++) res.r[i] = clamp32(a[i] - b[i], ov);
			end
			ACT_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					p0 = a[(i + 1) % 3] * b[(i + 2) % 3];
					p1 = a[(i + 2) % 3] * b[(i + 1) % 3];
					res.r[i] = clamp32(round_shift(p0 - p1), ov);
				end
			end
			ACT_DOT: begin
				p0 = a[0] * b[0];
				p1 = a[1] * b[1];
				p2 = a[2] * b[2];
				res.sc = clamp32(round_shift(p0 + p1 + p2), ov);
			end
			ACT_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					p0 = a[i] * s;
					res.r[i] = clamp32(round_shift(p0), ov);
				end
			end
			ACT_DIV: begin
				if (s == 0) begin
					res.dz = 1'b1;
					for (int i = 0; i < 3; i++) begin
						if (a[i] > 0) begin
							res.r[i] = 32'sh7fffffff;
							ov = 1'b1;
						end else if (a[i] < 0) begin
							res.r[i] = 32'sh80000000;
							ov = 1'b1;
						end
					end
				end else begin
					for (int i = 0; i < 3; i++) res.r[i] = fix_quotient(a[i], s, ov);
				end
			end
			ACT_NORM: begin
				sq = 0;
				for (int i = 0; i < 3; i++) sq += longint'(a[i] * a[i]);
				if (sq == 0) begin
					for (int i = 0; i < 3; i++) res.r[i] = op.a[i];
				end else begin
					mag = floor_sqrt(sq);
					for (int i = 0; i < 3; i++) res.r[i] = fix_quotient(a[i], longint'(mag), ov);
				end
			end
			default: begin
				res.sc = (a[0] == b[0] && a[1] == b[1] && a[2] == b[2]) ? 32'sd1 : 32'sd0;
			end
		endcase
		res.ov = ov;
		return res;
	endfunction

	// component value biased toward corners and small numbers
	function automatic fix_t pick_fix();
		case ($urandom_range(0, 7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return fix_t'($urandom_range(0, 8)) - 4;
			4, 5: return fix_t'($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
			default: return fix_t'($urandom);
		endcase
	endfunction

	function automatic op_beat_t make_op(action_t act, fix_t ax, fix_t ay, fix_t az,
			fix_t bx, fix_t by, fix_t bz, fix_t s);
		op_beat_t op;
		op.action = act;
		op.a[0] = ax; op.a[1] = ay; op.a[2] = az;
		op.b[0] = bx; op.b[1] = by; op.b[2] = bz;
		op.s = s;
		return op;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sender: bursts of beats separated by random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		op_beat_t op;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.action <= ACT_ADD;
			req.a_x <= '0; req.a_y <= '0; req.a_z <= '0;
			req.b_x <= '0; req.b_y <= '0; req.b_z <= '0;
			req.scalar_in <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!req.valid || req.ready) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				req.valid <= 1'b0;
			end else if (pending_ops.size() > 0) begin
				op = pending_ops.pop_front();
				req.valid <= 1'b1;
				req.action <= op.action;
				req.a_x <= op.a[0]; req.a_y <= op.a[1]; req.a_z <= op.a[2];
				req.b_x <= op.b[0]; req.b_y <= op.b[1]; req.b_z <= op.b[2];
				req.scalar_in <= op.s;
				awaited_results.push_back(vector_alu_result(op));
				op_count[op.action]++;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern switches in turn among four modes
	int stall_phase = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_phase <= 0;
		end else begin
			stall_phase <= stall_phase + 1;
			case ((stall_phase / 300) % 4)
				0: rsp.ready <= 1'b1;
				1: rsp.ready <= ($urandom_range(0, 1) == 1);
				2: rsp.ready <= (stall_phase % 5 == 0);
				default: rsp.ready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// response check against the oldest expectation
	always @(posedge clk) begin
		alu_result_t exp_res;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected response beat", $realtime);
			end else begin
				exp_res = awaited_results.pop_front();
				checked++;
				if (rsp.overflow) ov_seen++;
				if (rsp.div_zero) dz_seen++;
				if (rsp.r_x !== exp_res.r[0] || rsp.r_y !== exp_res.r[1] ||
						rsp.r_z !== exp_res.r[2] || rsp.scalar_out !== exp_res.sc ||
						rsp.overflow !== exp_res.ov || rsp.div_zero !== exp_res.dz) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch exp r=(%h %h %h) sc=%h ov=%b dz=%b got r=(%h %h %h) sc=%h ov=%b dz=%b",
							$realtime, exp_res.r[0], exp_res.r[1], exp_res.r[2], exp_res.sc,
							exp_res.ov, exp_res.dz, rsp.r_x, rsp.r_y, rsp.r_z,
							rsp.scalar_out, rsp.overflow, rsp.div_zero);
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// stimulus and end of run
	initial begin
		op_beat_t op;
		fix_t mx, mn;
		mx = 32'sh7fffffff;
		mn = 32'sh80000000;
		arst_n = 1'b0;
		for (int i = 0; i < 8; i++) op_count[i] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed corners
		pending_ops.push_back(make_op(ACT_ADD, mx, mn, 1, 1, -1, 2, 0));
		pending_ops.push_back(make_op(ACT_ADD, mn, mx, 0, mn, mx, 0, 0));
		pending_ops.push_back(make_op(ACT_SUB, mx, mn, 5, -1, 1, 7, 0));
		pending_ops.push_back(make_op(ACT_SUB, mn, 0, mx, mn, mx, mx, 0));
		pending_ops.push_back(make_op(ACT_CROSS, 32'sh10000, 0, 0, 0, 32'sh10000, 0, 0));
		pending_ops.push_back(make_op(ACT_CROSS, mx, mn, mx, mn, mx, mn, 0));
		pending_ops.push_back(make_op(ACT_CROSS, 1, 1, 1, 32'sh8000, -32'sh8000, 3, 0));
		pending_ops.push_back(make_op(ACT_DOT, mx, mx, mx, mx, mx, mx, 0));
		pending_ops.push_back(make_op(ACT_DOT, mn, mn, mn, mx, mx, mx, 0));
		pending_ops.push_back(make_op(ACT_DOT, 1, 0, 0, 32'sh8000, 0, 0, 0));
		pending_ops.push_back(make_op(ACT_DOT, -1, 0, 0, 32'sh8000, 0, 0, 0));
		pending_ops.push_back(make_op(ACT_SCALE, mx, mn, 32'sh10000, 0, 0, 0, mn));
		pending_ops.push_back(make_op(ACT_SCALE, 3, -3, 32'sh18000, 0, 0, 0, 32'sh8000));
		pending_ops.push_back(make_op(ACT_DIV, mx, mn, 0, 0, 0, 0, 0));
		pending_ops.push_back(make_op(ACT_DIV, 0, 0, 0, 0, 0, 0, 0));
		pending_ops.push_back(make_op(ACT_DIV, mx, mn, 3, 0, 0, 0, 1));
		pending_ops.push_back(make_op(ACT_DIV, mn, mx, -3, 0, 0, 0, -1));
		pending_ops.push_back(make_op(ACT_DIV, 32'sh10000, -32'sh10000, 1, 0, 0, 0, mn));
		pending_ops.push_back(make_op(ACT_NORM, 0, 0, 0, 1, 2, 3, 4));
		pending_ops.push_back(make_op(ACT_NORM, mn, mn, mn, 0, 0, 0, 0));
		pending_ops.push_back(make_op(ACT_NORM, 32'sh30000, 32'sh40000, 0, 0, 0, 0, 0));
		pending_ops.push_back(make_op(ACT_NORM, 1, 0, -1, 0, 0, 0, 0));
		pending_ops.push_back(make_op(ACT_EQ, mx, mn, 0, mx, mn, 0, 0));
		pending_ops.push_back(make_op(ACT_EQ, mx, mn, 0, mx, mn, 1, 0));

		// random operations
		for (int n = 0; n < N_RANDOM; n++) begin
			op.action = action_t'($urandom_range(0, 7));
			for (int i = 0; i < 3; i++) begin
				op.a[i] = pick_fix();
				op.b[i] = pick_fix();
			end
			op.s = pick_fix();
			if (op.action == ACT_EQ && $urandom_range(0, 1) == 1) begin
				op.b = op.a;
				if ($urandom_range(0, 2) == 0) op.b[$urandom_range(0, 2)] ^= 32'(1) << $urandom_range(0, 31);
			end
			if (op.action == ACT_DIV && $urandom_range(0, 4) == 0) op.s = '0;
			if (op.action == ACT_NORM && $urandom_range(0, 9) == 0) begin
				op.a[0] = '0; op.a[1] = '0; op.a[2] = '0;
			end
			pending_ops.push_back(op);
		end

		wait (pending_ops.size() == 0 && !req.valid);
		wait (awaited_results.size() == 0);
		repeat (200) @(posedge clk);

		$display("checked %0d results (add %0d sub %0d cross %0d dot %0d scale %0d div %0d norm %0d eq %0d)",
			checked, op_count[0], op_count[1], op_count[2], op_count[3],
			op_count[4], op_count[5], op_count[6], op_count[7]);
		$display("saturated results %0d, divide-by-zero results %0d, mismatches %0d",
			ov_seen, dz_seen, mismatches);
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
